FILE: hdl/wbpt_pkg.sv
// Shared types, constants and helpers for the work/break phase timer.
package wbpt_pkg;

   // Widths
   localparam int TIME_WIDTH     = 16;
   localparam int SESSION_WIDTH  = 16;
   localparam int LEN_WIDTH      = 8;
   localparam int IVL_WIDTH      = 4;
   localparam int CMD_WIDTH      = 3;
   localparam int EXT_WIDTH      = 12;
   localparam int PHASE_WIDTH    = 3;
   localparam int OUT_TIME_WIDTH = 16;
   localparam int MIN_WIDTH      = 11;
   localparam int SECS_WIDTH     = 6;
   localparam int DONE_WIDTH     = 2;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = 8;

   // Divider: dividend is the session count less one, divisor the long-break interval
   localparam int DIV_WIDTH     = SESSION_WIDTH;
   localparam int REM_WIDTH     = 6;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_WIDTH + 1);

   // Minutes split: floor(t / 60) = (t * 34953) >> 21, exact for 16-bit t
   localparam int                RECIP_SHIFT = 21;
   localparam int                PROD_WIDTH  = TIME_WIDTH + 16;
   localparam logic [15:0]       RECIP_60    = 16'd34953;

   // Intermediate width for a length scaled to seconds
   localparam int LEN_SEC_WIDTH = TIME_WIDTH + LEN_WIDTH;

   localparam logic [TIME_WIDTH-1:0]    TIME_MAX    = '1;
   localparam logic [SESSION_WIDTH-1:0] SESSION_MAX = '1;
   localparam logic [SESSION_WIDTH-1:0] SESSION_ONE = SESSION_WIDTH'(1);

   localparam logic [REM_WIDTH-1:0] SECS_PER_MIN = REM_WIDTH'(60);
   // interval of zero wraps like a 4-bit counter: modulo 16
   localparam logic [REM_WIDTH-1:0] MOD_ZERO_DIV = REM_WIDTH'(16);

   // Register reset values
   localparam logic [LEN_WIDTH-1:0] WORK_LEN_RST  = LEN_WIDTH'(25);
   localparam logic [LEN_WIDTH-1:0] SHORT_LEN_RST = LEN_WIDTH'(5);
   localparam logic [LEN_WIDTH-1:0] LONG_LEN_RST  = LEN_WIDTH'(15);
   localparam logic [IVL_WIDTH-1:0] INTERVAL_RST  = IVL_WIDTH'(4);

   typedef enum logic [PHASE_WIDTH-1:0] {
      PH_IDLE   = 3'd0,
      PH_WORK   = 3'd1,
      PH_SHORT  = 3'd2,
      PH_LONG   = 3'd3,
      PH_PAUSED = 3'd4
   } phase_type;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_TICK   = 3'd0,
      CMD_START  = 3'd1,
      CMD_PAUSE  = 3'd2,
      CMD_RESET  = 3'd3,
      CMD_SKIP   = 3'd4,
      CMD_EXTEND = 3'd5
   } cmd_type;

   typedef enum logic [DONE_WIDTH-1:0] {
      DONE_NONE  = 2'd0,
      DONE_WORK  = 2'd1,
      DONE_SHORT = 2'd2,
      DONE_LONG  = 2'd3
   } done_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_WORK_LEN     = 3'd0,
      CSR_SHORT_LEN    = 3'd1,
      CSR_LONG_LEN     = 3'd2,
      CSR_INTERVAL     = 3'd3,
      CSR_SECONDS_MODE = 3'd4
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MOD_START,
      ST_MOD_WAIT,
      ST_SEC_START,
      ST_SEC_WAIT,
      ST_OUT
   } fsm_type;

   typedef struct packed {
      logic                   start;
      logic [DIV_WIDTH-1:0]   dividend;
      logic [REM_WIDTH-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                   done;
      logic [REM_WIDTH-1:0]   remainder;
   } div_rsp_type;

   // Phase length in seconds: as is, or minutes times sixty (64x - 4x), saturated
   function automatic logic [TIME_WIDTH-1:0] length_secs(input logic [LEN_WIDTH-1:0] len,
                                                         input logic mode);
      logic [LEN_SEC_WIDTH-1:0] v;
      v = mode ? LEN_SEC_WIDTH'(len)
               : (LEN_SEC_WIDTH'(len) << 6) - (LEN_SEC_WIDTH'(len) << 2);
      if (v > LEN_SEC_WIDTH'(TIME_MAX)) begin
         length_secs = TIME_MAX;
      end else begin
         length_secs = TIME_WIDTH'(v);
      end
   endfunction

   // Saturating add of an extension to a time value
   function automatic logic [TIME_WIDTH-1:0] sat_add(input logic [TIME_WIDTH-1:0] t,
                                                     input logic [EXT_WIDTH-1:0] e);
      logic [TIME_WIDTH:0] s;
      s = {1'b0, t} + (TIME_WIDTH + 1)'(e);
      sat_add = s[TIME_WIDTH] ? TIME_MAX : s[TIME_WIDTH-1:0];
   endfunction

endpackage

FILE: hdl/wbpt_if.sv
// Command and result channel interfaces of the phase timer.
interface wbpt_req_if;
   import wbpt_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CMD_WIDTH-1:0] cmd;
   logic [EXT_WIDTH-1:0] extend_seconds;

   modport source (output valid, cmd, extend_seconds, input ready);
   modport sink   (input valid, cmd, extend_seconds, output ready);
endinterface

interface wbpt_rsp_if;
   import wbpt_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [PHASE_WIDTH-1:0]    phase;
   logic [OUT_TIME_WIDTH-1:0] remaining_time;
   logic [MIN_WIDTH-1:0]      remaining_minutes;
   logic [SECS_WIDTH-1:0]     remaining_secs_part;
   logic [OUT_TIME_WIDTH-1:0] phase_total;
   logic [SESSION_WIDTH-1:0]  session_number;
   logic                      is_running;
   logic                      phase_changed;
   logic [DONE_WIDTH-1:0]     completed_phase;

   modport source (output valid, phase, remaining_time, remaining_minutes,
                   remaining_secs_part, phase_total, session_number, is_running,
                   phase_changed, completed_phase,
                   input ready);
   modport sink   (input valid, phase, remaining_time, remaining_minutes,
                   remaining_secs_part, phase_total, session_number, is_running,
                   phase_changed, completed_phase,
                   output ready);
endinterface

FILE: hdl/work_break_phase_timer_unit.sv
// Work/break phase timer: one command word in, one status word out.
// A command word is taken only while the sequencer is idle. It passes through execution,
// the minutes split and the output load, which makes its status word valid; the sequencer
// then returns to idle and the next command can be taken. A command that completes a work
// phase also runs a modulo pass before the minutes split: the bit-serial divider spends 16
// steps on the session count less one modulo the long-break interval.
// Minutes and seconds are split by a registered multiply with the reciprocal of sixty.
// A finished status word waits in the output register while the next command is
// accepted; if it is still unread when the next word is ready, the sequencer holds and
// input stalls. Register writes take effect at the next phase load and must be made
// while no command is in flight.
module work_break_phase_timer_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   wbpt_req_if.sink                              req_chan,
   wbpt_rsp_if.source                            rsp_chan,
   input  logic                                  csr_we,
   input  logic [wbpt_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [wbpt_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import wbpt_pkg::*;

   // Configuration registers
   logic [LEN_WIDTH-1:0] work_len_ff, short_len_ff, long_len_ff;
   logic [IVL_WIDTH-1:0] interval_ff;
   logic                 sec_mode_ff;

   // Sequencer and timer state
   fsm_type                  state_ff, state_in;
   phase_type                phase_ff, phase_in;
   phase_type                saved_ff, saved_in;
   phase_type                before_ff, before_in;
   logic                     run_ff, run_in;
   logic [TIME_WIDTH-1:0]    secs_ff, secs_in;
   logic [TIME_WIDTH-1:0]    total_ff, total_in;
   logic [SESSION_WIDTH-1:0] session_ff, session_in;
   done_type                 done_ff, done_in;
   logic [CMD_WIDTH-1:0]     cmd_ff, cmd_in;
   logic [EXT_WIDTH-1:0]     ext_ff, ext_in;
   logic                     complete_go;
   logic                     mod_go;

   // Minutes/seconds split
   logic [PROD_WIDTH-1:0]    prod_ff, prod_in;
   logic [MIN_WIDTH-1:0]     min_ff, min_in;
   logic [SECS_WIDTH-1:0]    part_ff, part_in;
   logic [MIN_WIDTH-1:0]     min_quo;
   logic [TIME_WIDTH-1:0]    min_back;

   // Output word register
   logic                      rsp_valid_ff, rsp_valid_in;
   phase_type                 o_phase_ff, o_phase_in;
   logic [OUT_TIME_WIDTH-1:0] o_time_ff, o_time_in;
   logic [MIN_WIDTH-1:0]      o_min_ff, o_min_in;
   logic [SECS_WIDTH-1:0]     o_secs_ff, o_secs_in;
   logic [OUT_TIME_WIDTH-1:0] o_total_ff, o_total_in;
   logic [SESSION_WIDTH-1:0]  o_session_ff, o_session_in;
   logic                      o_run_ff, o_run_in;
   logic                      o_changed_ff, o_changed_in;
   done_type                  o_done_ff, o_done_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   wbpt_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Quotient from the registered reciprocal product, then back to seconds
   assign min_quo  = prod_ff[PROD_WIDTH-1:RECIP_SHIFT];
   assign min_back = TIME_WIDTH'(min_quo) * TIME_WIDTH'(SECS_PER_MIN);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         work_len_ff  <= WORK_LEN_RST;
         short_len_ff <= SHORT_LEN_RST;
         long_len_ff  <= LONG_LEN_RST;
         interval_ff  <= INTERVAL_RST;
         sec_mode_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WORK_LEN:     work_len_ff  <= csr_data;
            CSR_SHORT_LEN:    short_len_ff <= csr_data;
            CSR_LONG_LEN:     long_len_ff  <= csr_data;
            CSR_INTERVAL:     interval_ff  <= csr_data[IVL_WIDTH-1:0];
            CSR_SECONDS_MODE: sec_mode_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Sequencer: command execution, modulo pass, minutes split, then output load
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      saved_in     = saved_ff;
      before_in    = before_ff;
      run_in       = run_ff;
      secs_in      = secs_ff;
      total_in     = total_ff;
      session_in   = session_ff;
      done_in      = done_ff;
      cmd_in       = cmd_ff;
      ext_in       = ext_ff;
      prod_in      = prod_ff;
      min_in       = min_ff;
      part_in      = part_ff;
      complete_go  = 1'b0;
      mod_go       = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      o_phase_in   = o_phase_ff;
      o_time_in    = o_time_ff;
      o_min_in     = o_min_ff;
      o_secs_in    = o_secs_ff;
      o_total_in   = o_total_ff;
      o_session_in = o_session_ff;
      o_run_in     = o_run_ff;
      o_changed_in = o_changed_ff;
      o_done_in    = o_done_ff;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               cmd_in   = req_chan.cmd;
               ext_in   = req_chan.extend_seconds;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            before_in = phase_ff;
            done_in   = DONE_NONE;
            case (cmd_ff)
               CMD_TICK: begin
                  if (run_ff) begin
                     if (secs_ff != '0) begin
                        secs_in = secs_ff - TIME_WIDTH'(1);
                     end else begin
                        complete_go = 1'b1;
                     end
                  end
               end
               CMD_START: begin
                  if (phase_ff == PH_IDLE) begin
                     phase_in = PH_WORK;
                     secs_in  = length_secs(work_len_ff, sec_mode_ff);
                     total_in = length_secs(work_len_ff, sec_mode_ff);
                  end else if (phase_ff == PH_PAUSED) begin
                     phase_in = saved_ff;
                  end
                  run_in = 1'b1;
               end
               CMD_PAUSE: begin
                  run_in = 1'b0;
                  if (phase_ff != PH_IDLE && phase_ff != PH_PAUSED) begin
                     saved_in = phase_ff;
                     phase_in = PH_PAUSED;
                  end
               end
               CMD_RESET: begin
                  run_in     = 1'b0;
                  session_in = SESSION_ONE;
                  saved_in   = PH_IDLE;
                  phase_in   = PH_IDLE;
                  secs_in    = length_secs(work_len_ff, sec_mode_ff);
                  total_in   = length_secs(work_len_ff, sec_mode_ff);
               end
               CMD_SKIP: begin
                  run_in = 1'b0;
                  if (phase_ff == PH_WORK) begin
                     complete_go = 1'b1;
                  end else if (phase_ff == PH_SHORT || phase_ff == PH_LONG) begin
                     phase_in = PH_WORK;
                     secs_in  = length_secs(work_len_ff, sec_mode_ff);
                     total_in = length_secs(work_len_ff, sec_mode_ff);
                     run_in   = 1'b1;
                  end
               end
               CMD_EXTEND: begin
                  if (phase_ff == PH_SHORT || phase_ff == PH_LONG) begin
                     secs_in  = sat_add(secs_ff, ext_ff);
                     total_in = sat_add(total_ff, ext_ff);
                  end
               end
               default: ;
            endcase

            // Phase completion; work picks its break after the modulo pass
            if (complete_go) begin
               case (phase_ff)
                  PH_WORK: begin
                     if (session_ff != SESSION_MAX) begin
                        session_in = session_ff + SESSION_ONE;
                     end
                     run_in  = 1'b1;
                     done_in = DONE_WORK;
                     mod_go  = 1'b1;
                  end
                  PH_SHORT, PH_LONG: begin
                     done_in  = (phase_ff == PH_SHORT) ? DONE_SHORT : DONE_LONG;
                     phase_in = PH_IDLE;
                     secs_in  = length_secs(work_len_ff, sec_mode_ff);
                     total_in = length_secs(work_len_ff, sec_mode_ff);
                     run_in   = 1'b0;
                  end
                  default: run_in = 1'b0;
               endcase
            end
            state_in = mod_go ? ST_MOD_START : ST_SEC_START;
         end
         ST_MOD_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_WIDTH'(session_ff - SESSION_ONE);
            div_req.divisor  = (interval_ff == '0) ? MOD_ZERO_DIV : REM_WIDTH'(interval_ff);
            state_in         = ST_MOD_WAIT;
         end
         ST_MOD_WAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.remainder == '0) begin
                  phase_in = PH_LONG;
                  secs_in  = length_secs(long_len_ff, sec_mode_ff);
                  total_in = length_secs(long_len_ff, sec_mode_ff);
               end else begin
                  phase_in = PH_SHORT;
                  secs_in  = length_secs(short_len_ff, sec_mode_ff);
                  total_in = length_secs(short_len_ff, sec_mode_ff);
               end
               state_in = ST_SEC_START;
            end
         end
         ST_SEC_START: begin
            prod_in  = PROD_WIDTH'(secs_ff) * PROD_WIDTH'(RECIP_60);
            state_in = ST_SEC_WAIT;
         end
         ST_SEC_WAIT: begin
            min_in   = min_quo;
            part_in  = SECS_WIDTH'(secs_ff - min_back);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               o_phase_in   = phase_ff;
               o_time_in    = OUT_TIME_WIDTH'(secs_ff);
               o_min_in     = min_ff;
               o_secs_in    = part_ff;
               o_total_in   = OUT_TIME_WIDTH'(total_ff);
               o_session_in = session_ff;
               o_run_in     = run_ff;
               o_changed_in = (phase_ff != before_ff);
               o_done_in    = done_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_IDLE;
         saved_ff     <= PH_IDLE;
         before_ff    <= PH_IDLE;
         run_ff       <= 1'b0;
         secs_ff      <= length_secs(WORK_LEN_RST, 1'b0);
         total_ff     <= length_secs(WORK_LEN_RST, 1'b0);
         session_ff   <= SESSION_ONE;
         done_ff      <= DONE_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         saved_ff     <= saved_in;
         before_ff    <= before_in;
         run_ff       <= run_in;
         secs_ff      <= secs_in;
         total_ff     <= total_in;
         session_ff   <= session_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      ext_ff       <= ext_in;
      prod_ff      <= prod_in;
      min_ff       <= min_in;
      part_ff      <= part_in;
      o_phase_ff   <= o_phase_in;
      o_time_ff    <= o_time_in;
      o_min_ff     <= o_min_in;
      o_secs_ff    <= o_secs_in;
      o_total_ff   <= o_total_in;
      o_session_ff <= o_session_in;
      o_run_ff     <= o_run_in;
      o_changed_ff <= o_changed_in;
      o_done_ff    <= o_done_in;
   end

   // Ports
   assign req_chan.ready               = (state_ff == ST_IDLE);
   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.phase               = o_phase_ff;
   assign rsp_chan.remaining_time      = o_time_ff;
   assign rsp_chan.remaining_minutes   = o_min_ff;
   assign rsp_chan.remaining_secs_part = o_secs_ff;
   assign rsp_chan.phase_total         = o_total_ff;
   assign rsp_chan.session_number      = o_session_ff;
   assign rsp_chan.is_running          = o_run_ff;
   assign rsp_chan.phase_changed       = o_changed_ff;
   assign rsp_chan.completed_phase     = o_done_ff;

   // Checks
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == ST_EXEC))
      else $error("accepted word did not enter execution");

   a_run_phase: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> (phase_ff != PH_IDLE && phase_ff != PH_PAUSED))
      else $error("timer running while idle or paused");

   a_secs_le_total: assert property (@(posedge clock) disable iff (reset)
      secs_ff <= total_ff)
      else $error("remaining time exceeds phase length");

   a_session_nonzero: assert property (@(posedge clock) disable iff (reset)
      session_ff != '0)
      else $error("session count reached zero");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_MOD_WAIT))
      else $error("divider finished outside the modulo wait");

endmodule

FILE: hdl/wbpt_div.sv
// Bit-serial restoring divider for the session count modulo: one quotient bit per cycle.
module wbpt_div (
   input  logic                  clock,
   input  logic                  reset,
   input  wbpt_pkg::div_req_type req,
   output wbpt_pkg::div_rsp_type rsp
);
   import wbpt_pkg::*;

   logic [DIV_WIDTH-1:0]     quo_ff, quo_in;
   logic [REM_WIDTH-1:0]     rem_ff, rem_in;
   logic [REM_WIDTH-1:0]     dsr_ff, dsr_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [REM_WIDTH:0]       trial;
   logic                     qbit;

   // One restoring step: shift in next dividend bit, subtract if it fits
   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_WIDTH-1]};
      qbit    = (trial >= {1'b0, dsr_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
         cnt_in  = DIV_CNT_WIDTH'(DIV_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = qbit ? REM_WIDTH'(trial - {1'b0, dsr_ff}) : REM_WIDTH'(trial);
         quo_in = {quo_ff[DIV_WIDTH-2:0], qbit};
         cnt_in = cnt_ff - DIV_CNT_WIDTH'(1);
         if (cnt_ff == DIV_CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the work/break phase timer: command words in, status words out.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import wbpt_pkg::*;

   // Codes outside the command set; the block must treat them as no-ops
   localparam logic [CMD_WIDTH-1:0] CMD_SPARE_A = 3'd6;
   localparam logic [CMD_WIDTH-1:0] CMD_SPARE_B = 3'd7;
   localparam int unsigned MINUTE_SECS = 60;
   localparam logic [EXT_WIDTH-1:0] EXT_MAX = '1;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 60;

   typedef struct packed {
      logic [CMD_WIDTH-1:0] cmd;
      logic [EXT_WIDTH-1:0] ext;
   } cmd_word_type;

   typedef struct packed {
      logic [PHASE_WIDTH-1:0]    phase;
      logic [OUT_TIME_WIDTH-1:0] remaining_time;
      logic [MIN_WIDTH-1:0]      remaining_minutes;
      logic [SECS_WIDTH-1:0]     remaining_secs_part;
      logic [OUT_TIME_WIDTH-1:0] phase_total;
      logic [SESSION_WIDTH-1:0]  session_number;
      logic                      is_running;
      logic                      phase_changed;
      logic [DONE_WIDTH-1:0]     completed_phase;
   } status_word_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_data;

   wbpt_req_if req_bus ();
   wbpt_rsp_if rsp_bus ();

   work_break_phase_timer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   cmd_word_type    pending_words[$];
   status_word_type status_expect[$];
   int              fail_count = 0;
   int unsigned     send_idle_pct = 0;
   int unsigned     recv_idle_pct = 0;
   int              hold_asks = 0;
   int              hold_taken = 0;
   int              hold_left = 0;

   // Timer model state and its copy of the registers
   logic [LEN_WIDTH-1:0]     work_len_cfg, short_len_cfg, long_len_cfg;
   logic [IVL_WIDTH-1:0]     ivl_cfg;
   logic                     secs_mode_cfg;
   phase_type                cur_phase, held_phase;
   logic                     running;
   logic [TIME_WIDTH-1:0]    secs_left, phase_len;
   logic [SESSION_WIDTH-1:0] sess_num;

   // Enter a phase; idle preloads the work length
   function automatic void enter_phase(phase_type ph);
      int unsigned len;
      cur_phase = ph;
      case (ph)
         PH_SHORT: len = 32'(short_len_cfg);
         PH_LONG:  len = 32'(long_len_cfg);
         default:  len = 32'(work_len_cfg);
      endcase
      if (!secs_mode_cfg) len = len * MINUTE_SECS;
      secs_left = (len > TIME_MAX) ? TIME_MAX : TIME_WIDTH'(len);
      phase_len = secs_left;
   endfunction

   function automatic logic [TIME_WIDTH-1:0] add_sat(logic [TIME_WIDTH-1:0] t,
                                                      logic [EXT_WIDTH-1:0] e);
      int unsigned sum;
      sum = 32'(t) + 32'(e);
      return (sum > TIME_MAX) ? TIME_MAX : TIME_WIDTH'(sum);
   endfunction

   // End of the current phase: work moves to a break, a break goes idle
   function automatic done_type finish_phase();
      logic [4:0] div;
      done_type   which;
      if (cur_phase == PH_WORK) begin
         div = (ivl_cfg == '0) ? 5'd16 : {1'b0, ivl_cfg};
         if (sess_num != SESSION_MAX) sess_num = sess_num + SESSION_ONE;
         enter_phase((((sess_num - SESSION_ONE) % SESSION_WIDTH'(div)) == '0) ?
                     PH_LONG : PH_SHORT);
         running = 1'b1;
         return DONE_WORK;
      end
      if (cur_phase == PH_SHORT || cur_phase == PH_LONG) begin
         which = (cur_phase == PH_SHORT) ? DONE_SHORT : DONE_LONG;
         enter_phase(PH_IDLE);
         running = 1'b0;
         return which;
      end
      running = 1'b0;
      return DONE_NONE;
   endfunction

   // Apply one command word to the model and return the status word it produces
   function automatic status_word_type timer_step(logic [CMD_WIDTH-1:0] cmd,
                                                  logic [EXT_WIDTH-1:0] ext);
      phase_type       prior;
      done_type        done;
      status_word_type s;
      prior = cur_phase;
      done = DONE_NONE;
      case (cmd)
         CMD_TICK: begin
            if (running) begin
               if (secs_left != '0) secs_left = secs_left - TIME_WIDTH'(1);
               else done = finish_phase();
            end
         end
         CMD_START: begin
            if (cur_phase == PH_IDLE) enter_phase(PH_WORK);
            else if (cur_phase == PH_PAUSED) cur_phase = held_phase;
            running = 1'b1;
         end
         CMD_PAUSE: begin
            running = 1'b0;
            if (cur_phase != PH_IDLE && cur_phase != PH_PAUSED) begin
               held_phase = cur_phase;
               cur_phase = PH_PAUSED;
            end
         end
         CMD_RESET: begin
            running = 1'b0;
            sess_num = SESSION_ONE;
            held_phase = PH_IDLE;
            enter_phase(PH_IDLE);
         end
         CMD_SKIP: begin
            running = 1'b0;
            if (cur_phase == PH_WORK) begin
               done = finish_phase();
            end else if (cur_phase == PH_SHORT || cur_phase == PH_LONG) begin
               enter_phase(PH_WORK);
               running = 1'b1;
            end
         end
         CMD_EXTEND: begin
            if (cur_phase == PH_SHORT || cur_phase == PH_LONG) begin
               secs_left = add_sat(secs_left, ext);
               phase_len = add_sat(phase_len, ext);
            end
         end
         default: ;
      endcase
      s.phase = cur_phase;
      s.remaining_time = secs_left;
      s.remaining_minutes = MIN_WIDTH'(secs_left / MINUTE_SECS);
      s.remaining_secs_part = SECS_WIDTH'(secs_left % MINUTE_SECS);
      s.phase_total = phase_len;
      s.session_number = sess_num;
      s.is_running = running;
      s.phase_changed = (cur_phase != prior);
      s.completed_phase = done;
      return s;
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Weighted random command; ticks dominate so phases run out
   function automatic cmd_word_type random_word();
      cmd_word_type w;
      int unsigned  r;
      r = $urandom_range(99);
      w.ext = EXT_WIDTH'($urandom_range(4095));
      if (r < 50) begin
         w.cmd = CMD_TICK;
      end else if (r < 62) begin
         w.cmd = CMD_START;
      end else if (r < 68) begin
         w.cmd = CMD_PAUSE;
      end else if (r < 71) begin
         w.cmd = CMD_RESET;
      end else if (r < 81) begin
         w.cmd = CMD_SKIP;
      end else if (r < 93) begin
         w.cmd = CMD_EXTEND;
         case ($urandom_range(7))
            0, 1:    w.ext = EXT_MAX;
            2:       w.ext = '0;
            default: w.ext = EXT_WIDTH'($urandom_range(30));
         endcase
      end else begin
         w.cmd = ($urandom_range(1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;
      end
      return w;
   endfunction

   task automatic queue_word(logic [CMD_WIDTH-1:0] cmd, logic [EXT_WIDTH-1:0] ext);
      cmd_word_type w;
      w.cmd = cmd;
      w.ext = ext;
      pending_words.push_back(w);
   endtask

   task automatic run_random(int count);
      int n;
      n = 0;
      while (n < count) begin
         if ($urandom_range(59) == 0) begin
            // break pushed past the time ceiling by repeated extensions
            queue_word(CMD_RESET, EXT_WIDTH'($urandom_range(4095)));
            queue_word(CMD_START, EXT_WIDTH'($urandom_range(4095)));
            queue_word(CMD_SKIP, EXT_WIDTH'($urandom_range(4095)));
            repeat (17) queue_word(CMD_EXTEND, EXT_MAX);
            n += 20;
         end else begin
            pending_words.push_back(random_word());
            n++;
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_bus.valid || status_expect.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      case (idx)
         CSR_WORK_LEN:     work_len_cfg = value;
         CSR_SHORT_LEN:    short_len_cfg = value;
         CSR_LONG_LEN:     long_len_cfg = value;
         CSR_INTERVAL:     ivl_cfg = value[IVL_WIDTH-1:0];
         CSR_SECONDS_MODE: secs_mode_cfg = value[0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic [7:0] work_len, logic [7:0] short_len,
                             logic [7:0] long_len, logic [3:0] ivl, logic mode);
      write_reg(CSR_WORK_LEN, work_len);
      write_reg(CSR_SHORT_LEN, short_len);
      write_reg(CSR_LONG_LEN, long_len);
      write_reg(CSR_INTERVAL, {4'b0, ivl});
      write_reg(CSR_SECONDS_MODE, {7'b0, mode});
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Command driver: a word stays on the bus until taken
   always @(posedge clock) begin : drive
      cmd_word_type next_word;
      if (reset) begin
         req_bus.valid <= 1'b0;
         running = 1'b0;
         held_phase = PH_IDLE;
         sess_num = SESSION_ONE;
         enter_phase(PH_IDLE);
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            status_expect.push_back(timer_step(req_bus.cmd, req_bus.extend_seconds));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_word = pending_words.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.cmd <= next_word.cmd;
               req_bus.extend_seconds <= next_word.ext;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Status monitor and receiver back-pressure
   always @(posedge clock) begin : observe
      status_word_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (status_expect.size() == 0) begin
               $error("status word with none expected");
               fail_count++;
            end else begin
               want = status_expect.pop_front();
               check_field("phase", 16'(want.phase), 16'(rsp_bus.phase));
               check_field("remaining_time", want.remaining_time, rsp_bus.remaining_time);
               check_field("remaining_minutes", 16'(want.remaining_minutes),
                           16'(rsp_bus.remaining_minutes));
               check_field("remaining_secs_part", 16'(want.remaining_secs_part),
                           16'(rsp_bus.remaining_secs_part));
               check_field("phase_total", want.phase_total, rsp_bus.phase_total);
               check_field("session_number", want.session_number, rsp_bus.session_number);
               check_field("is_running", 16'(want.is_running), 16'(rsp_bus.is_running));
               check_field("phase_changed", 16'(want.phase_changed),
                           16'(rsp_bus.phase_changed));
               check_field("completed_phase", 16'(want.completed_phase),
                           16'(rsp_bus.completed_phase));
            end
         end
         if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (hold_asks != hold_taken) begin
            rsp_bus.ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_taken <= hold_asks;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Stimulus sequence
   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;

      work_len_cfg = WORK_LEN_RST;
      short_len_cfg = SHORT_LEN_RST;
      long_len_cfg = LONG_LEN_RST;
      ivl_cfg = INTERVAL_RST;
      secs_mode_cfg = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed walk through the command set at reset settings
      send_idle_pct = 19;
      recv_idle_pct = 49;
      queue_word(CMD_TICK, EXT_MAX);       // tick while stopped
      queue_word(CMD_SPARE_A, EXT_MAX);
      queue_word(CMD_SPARE_B, '0);
      queue_word(CMD_PAUSE, '0);           // pause in idle
      queue_word(CMD_SKIP, '0);            // skip in idle
      queue_word(CMD_EXTEND, EXT_MAX);     // extend outside a break
      queue_word(CMD_START, '0);           // idle to work
      queue_word(CMD_START, '0);           // start while running
      queue_word(CMD_TICK, '0);
      queue_word(CMD_TICK, '0);
      queue_word(CMD_EXTEND, EXT_MAX);     // ignored in work
      queue_word(CMD_PAUSE, '0);
      queue_word(CMD_PAUSE, '0);           // pause while paused
      queue_word(CMD_SKIP, '0);            // skip while paused
      queue_word(CMD_TICK, '0);
      queue_word(CMD_START, '0);           // resume work
      queue_word(CMD_SKIP, '0);            // skip in work completes it
      queue_word(CMD_EXTEND, EXT_MAX);
      queue_word(CMD_EXTEND, '0);
      queue_word(CMD_PAUSE, '0);
      queue_word(CMD_START, '0);           // resume break
      queue_word(CMD_SKIP, '0);            // skip in break back to work
      queue_word(CMD_RESET, EXT_MAX);
      wait_drained();

      // Short seconds-mode phases, with one long receiver stall
      set_config(8'd3, 8'd2, 8'd4, 4'd2, 1'b1);
      hold_asks = hold_asks + 1;
      run_random(340);
      wait_drained();

      // Zero lengths, interval zero wraps to sixteen
      set_config(8'd0, 8'd0, 8'd0, 4'd0, 1'b1);
      run_random(340);
      wait_drained();

      send_idle_pct = 49;
      recv_idle_pct = 19;
      set_config(8'd255, 8'd255, 8'd255, 4'd15, 1'b0);
      run_random(200);
      wait_drained();

      set_config(8'd7, 8'd1, 8'd255, 4'd1, 1'b1);
      run_random(340);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_config(8'($urandom_range(12)), 8'($urandom_range(12)), 8'($urandom_range(12)),
                 4'($urandom_range(15)), 1'b1);
      run_random(340);
      wait_drained();

      set_config(8'd1, 8'd0, 8'd2, 4'd3, 1'b0);
      run_random(400);
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && status_expect.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
